/* src/mcd_pkg.sv */
// ----------------------------------------------------------------------------
// mcd_pkg
// Types and constants shared by the match/copy decoder modules.
// ----------------------------------------------------------------------------
package mcd_pkg;

  localparam int LEN_W  = 6;
  localparam int DIST_W = 7;
  localparam int SYM_W  = 8;

  typedef struct packed {
    logic [LEN_W-1:0]  match_length;
    logic [DIST_W-1:0] match_distance;
    logic [SYM_W-1:0]  raw_symbol;
  } mcd_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_run;
    logic             distance_error;
  } mcd_out_t;

  typedef enum logic {
    MCD_IDLE,
    MCD_COPY
  } mcd_state_e;

  // controls from the sequencer to the history cells
  typedef struct packed {
    logic shift_en;
    logic sel_load;
    logic copy_busy;
  } mcd_chain_ctrl_t;

endpackage

/* src/mcd_cell.sv */
// ----------------------------------------------------------------------------
// mcd_cell
// One history slot: holds a symbol, passes it to the next slot on a shift and
// drives it onto the tap bus when its slot is the copy source.
// ----------------------------------------------------------------------------
module mcd_cell #(
  parameter int SYMBOL_BITS = 8,
  parameter int CELL_INDEX  = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mcd_pkg::mcd_chain_ctrl_t         ctrl_i,
  input  logic [mcd_pkg::DIST_W-1:0]       dist_m1_i,
  input  logic [SYMBOL_BITS-1:0]           sym_i,
  output logic [SYMBOL_BITS-1:0]           sym_o,
  output logic [SYMBOL_BITS-1:0]           tap_o,
  output logic                             sel_o
);
  import mcd_pkg::*;

  logic [SYMBOL_BITS-1:0] sym_q;
  logic                   sel_q;
  logic                   hit;

  assign hit = (32'(dist_m1_i) == 32'(CELL_INDEX));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      sym_q <= sym_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (ctrl_i.sel_load) begin
      sel_q <= hit;
    end
  end

  assign sym_o = sym_q;
  assign tap_o = sym_q & {SYMBOL_BITS{sel_q}};
  assign sel_o = sel_q;

endmodule

/* src/mcd_ctrl.sv */
// ----------------------------------------------------------------------------
// mcd_ctrl
// Token sequencer: decodes literals and matches, checks the distance against
// the produced count, steps a copy one symbol per beat and holds the output.
// ----------------------------------------------------------------------------
module mcd_ctrl #(
  parameter int HISTORY_DEPTH = 64,
  parameter int SYMBOL_BITS   = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mcd_pkg::mcd_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mcd_pkg::mcd_out_t          out_data_o,
  input  logic [SYMBOL_BITS-1:0]     tap_sym_i,
  output logic [SYMBOL_BITS-1:0]     head_sym_o,
  output logic [mcd_pkg::DIST_W-1:0] dist_m1_o,
  output mcd_pkg::mcd_chain_ctrl_t   chain_ctrl_o
);
  import mcd_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (CNT_W > DIST_W) ? CNT_W : DIST_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(HISTORY_DEPTH);

  mcd_state_e         state_q, state_d;
  logic [LEN_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q, out_valid_d;
  mcd_out_t           out_q, out_d;

  logic               out_free;
  logic               accept;
  logic               dist_bad;
  logic [SYMBOL_BITS-1:0] raw_sym;

  assign out_free = !out_valid_q || out_ready_i;
  assign raw_sym  = SYMBOL_BITS'(in_data_i.raw_symbol);
  assign dist_bad = (in_data_i.match_distance == '0) ||
                    (CMP_W'(in_data_i.match_distance) > CMP_W'(count_q));
  assign dist_m1_o = in_data_i.match_distance - DIST_W'(1);
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    head_sym_o  = tap_sym_i;
    in_ready_o  = 1'b0;
    chain_ctrl_o.shift_en  = 1'b0;
    chain_ctrl_o.sel_load  = 1'b0;
    chain_ctrl_o.copy_busy = (state_q == MCD_COPY);

    unique case (state_q)
      MCD_IDLE: begin
        in_ready_o = out_free;
        if (accept) begin
          out_valid_d = 1'b1;
          if (in_data_i.match_length == '0) begin
            out_d.symbol         = SYM_W'(raw_sym);
            out_d.last_of_run    = 1'b1;
            out_d.distance_error = 1'b0;
            head_sym_o           = raw_sym;
            chain_ctrl_o.shift_en = 1'b1;
            if (count_q != CNT_MAX) begin
              count_d = count_q + CNT_W'(1);
            end
          end else if (dist_bad) begin
            out_d.symbol         = '0;
            out_d.last_of_run    = 1'b1;
            out_d.distance_error = 1'b1;
          end else begin
            // enter the copy state, nothing to show yet
            out_valid_d           = out_valid_q && !out_ready_i;
            chain_ctrl_o.sel_load = 1'b1;
            rem_d                 = in_data_i.match_length;
            state_d               = MCD_COPY;
          end
        end
      end
      MCD_COPY: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.symbol         = SYM_W'(tap_sym_i);
          out_d.last_of_run    = (rem_q == LEN_W'(1));
          out_d.distance_error = 1'b0;
          chain_ctrl_o.shift_en = 1'b1;
          if (count_q != CNT_MAX) begin
            count_d = count_q + CNT_W'(1);
          end
          rem_d = rem_q - LEN_W'(1);
          if (rem_q == LEN_W'(1)) begin
            state_d = MCD_IDLE;
          end
        end
      end
      default: begin
        state_d = MCD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= MCD_IDLE;
      rem_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/match_copy_decoder_unit.sv */
// ----------------------------------------------------------------------------
// match_copy_decoder_unit
// Match/copy token decoder built on a shifting row of history cells.
// ----------------------------------------------------------------------------
// output: a literal or a distance error is registered into the output on the
//   edge it is taken; a match first selects its source cell and enters the copy
//   state, then registers each copied symbol into the output; the input is
//   not ready during a copy, which gives one symbol per cycle while the output is not stalled
// reset: sequencer idle, produced count zero, output empty; history contents
//   are not cleared
module match_copy_decoder_unit #(
  parameter int HISTORY_DEPTH = 64,
  parameter int SYMBOL_BITS   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mcd_pkg::mcd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mcd_pkg::mcd_out_t out_data_o
);
  import mcd_pkg::*;

  mcd_chain_ctrl_t        chain_ctrl;
  logic [DIST_W-1:0]      dist_m1;
  logic [SYMBOL_BITS-1:0] head_sym;
  logic [SYMBOL_BITS-1:0] tap_sym;
  logic [SYMBOL_BITS-1:0] cell_sym [HISTORY_DEPTH];
  logic [SYMBOL_BITS-1:0] cell_tap [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] cell_sel;

  mcd_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SYMBOL_BITS   (SYMBOL_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .tap_sym_i    (tap_sym),
    .head_sym_o   (head_sym),
    .dist_m1_o    (dist_m1),
    .chain_ctrl_o (chain_ctrl)
  );

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic [SYMBOL_BITS-1:0] sym_in;
    if (i == 0) begin : g_head
      assign sym_in = head_sym;
    end else begin : g_body
      assign sym_in = cell_sym[i-1];
    end
    mcd_cell #(
      .SYMBOL_BITS (SYMBOL_BITS),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (chain_ctrl),
      .dist_m1_i (dist_m1),
      .sym_i     (sym_in),
      .sym_o     (cell_sym[i]),
      .tap_o     (cell_tap[i]),
      .sel_o     (cell_sel[i])
    );
  end

  // only the source cell drives a nonzero tap
  always_comb begin
    tap_sym = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      tap_sym = tap_sym | cell_tap[i];
    end
  end

  a_busy_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_ctrl.copy_busy |-> !in_ready_o)
    else $error("input taken during a copy");

  a_one_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_ctrl.copy_busy |-> $onehot(cell_sel))
    else $error("copy source is not a single cell");

  a_error_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.distance_error |->
      out_data_o.last_of_run && (out_data_o.symbol == '0))
    else $error("error beat carries data or is not last");

  a_load_then_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_ctrl.sel_load |=> chain_ctrl.copy_busy)
    else $error("source selected without a copy");

endmodule
